// ----- design/btpa_pkg.sv -----
package btpa_pkg;

  // Pool geometry
  localparam int POOL_WORDS   = 4096;
  localparam int HANDLE_LIMIT = 4096;
  localparam int ACTIVE_MAX   = (POOL_WORDS < HANDLE_LIMIT) ? POOL_WORDS : HANDLE_LIMIT;
  localparam int ACTIVE_MIN   = 8;
  localparam int ADDR_W       = $clog2(POOL_WORDS);
  localparam int OFF_W        = $clog2(ACTIVE_MAX + 1);

  // Field and word widths
  localparam int FIELD_W = 12;
  localparam int CFG_W   = 13;
  localparam int WORD_W  = 32;
  localparam int SIZE_W  = 31;
  localparam int HDR     = 2;

  localparam logic [WORD_W-1:0] FLAG_ALLOC = 32'h8000_0000;
  localparam logic [WORD_W-1:0] SIZE_MASK  = 32'h7fff_ffff;

  typedef logic [1:0]         op_t;
  typedef logic [1:0]         status_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Operations
  localparam op_t OP_FORMAT = 2'd0;
  localparam op_t OP_ALLOC  = 2'd1;
  localparam op_t OP_FREE   = 2'd2;

  // Result status
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_NOFIT   = 2'd1;
  localparam status_t STATUS_BAD_HDL = 2'd2;
  localparam status_t STATUS_BAD_REQ = 2'd3;

endpackage

// ----- design/btpa_req_if.sv -----
interface btpa_req_if;
  import btpa_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  field_t request_words;
  field_t handle;

  modport source (output valid, output operation, output request_words, output handle,
                  input ready);
  modport sink   (input valid, input operation, input request_words, input handle,
                  output ready);
endinterface

// ----- design/btpa_rsp_if.sv -----
interface btpa_rsp_if;
  import btpa_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  field_t  granted_handle;

  modport source (output valid, output status, output granted_handle, input ready);
  modport sink   (input valid, input status, input granted_handle, output ready);
endinterface

// ----- design/boundary_tag_pool_allocator_core.sv -----
// First-fit boundary-tag allocator over a 4096 x 32 pool RAM. Each block has a
// two-word header (back link, size with bit 31 = allocated); an allocated
// size-zero header ends the pool. One beat is handled at a time and the RAM is
// accessed one word at a time: format writes four header words, a successful
// free reads the block's header and the size words of its neighbours before
// writing two words, and allocate reads one size word per header visited and
// writes two words when it takes the whole block or five when it splits, so
// allocate time grows with the number of blocks ahead of the first fit.
// A result beat waiting at the output does not block the next request beat.
// pool_words may be written only while the block is idle; run a format after
// changing it. Pool contents are undefined until the first format.
module boundary_tag_pool_allocator_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [btpa_pkg::CFG_W-1:0] cfg_wdata,
  btpa_req_if.sink                req,
  btpa_rsp_if.source              rsp
);
  import btpa_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FMT   = 4'd1;
  localparam logic [3:0] ST_ACHK  = 4'd2;
  localparam logic [3:0] ST_AEVAL = 4'd3;
  localparam logic [3:0] ST_AWR   = 4'd4;
  localparam logic [3:0] ST_FCHK  = 4'd5;
  localparam logic [3:0] ST_FW    = 4'd6;
  localparam logic [3:0] ST_FP    = 4'd7;
  localparam logic [3:0] ST_FPF   = 4'd8;
  localparam logic [3:0] ST_FNF   = 4'd9;
  localparam logic [3:0] ST_FCMP  = 4'd10;
  localparam logic [3:0] ST_FWR   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]        state;
  logic [2:0]        step;
  logic [CFG_W-1:0]  pool_words;
  logic [OFF_W-1:0]  limit;
  field_t            req_words;
  field_t            hdl;
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  prev_off;
  logic [OFF_W-1:0]  nxt;
  logic [OFF_W-1:0]  mod_off;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W+2:0] total;
  logic [SIZE_W+1:0] new_next;
  status_t           res_status;
  field_t            res_grant;
  logic              rsp_valid;
  status_t           rsp_status;
  field_t            rsp_grant;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [SIZE_W-1:0] rd_size;
  logic [WORD_W-1:0] walk_end;
  logic [WORD_W-1:0] free_end;
  logic [SIZE_W-1:0] leftover;
  logic              take_whole;
  logic [OFF_W-1:0]  split_at;
  logic [OFF_W-1:0]  follow;
  logic [OFF_W-1:0]  active_n;

  btpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_WORDS)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.granted_handle = rsp_grant;

  // Saturated pool size taken at request time
  always_comb begin
    if (pool_words > CFG_W'(ACTIVE_MAX)) begin
      active_n = OFF_W'(ACTIVE_MAX);
    end else if (pool_words < CFG_W'(ACTIVE_MIN)) begin
      active_n = OFF_W'(ACTIVE_MIN);
    end else begin
      active_n = OFF_W'(pool_words);
    end
  end

  // Header arithmetic
  assign rd_size    = SIZE_W'(ram_rdata & SIZE_MASK);
  assign walk_end   = WORD_W'(off) + WORD_W'(HDR) + WORD_W'(rd_size);
  assign free_end   = WORD_W'(off) + WORD_W'(HDR) + WORD_W'(size_q);
  assign leftover   = size_q - SIZE_W'(req_words);
  assign take_whole = (leftover <= SIZE_W'(HDR));
  assign split_at   = off + OFF_W'(HDR) + OFF_W'(req_words);
  assign follow     = OFF_W'(free_end);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      ST_FMT: begin
        ram_we = 1'b1;
        unique case (step)
          3'd0: begin
            ram_waddr = '0;
            ram_wdata = '0;
          end
          3'd1: begin
            ram_waddr = ADDR_W'(1);
            ram_wdata = WORD_W'(limit) - WORD_W'(HDR);
          end
          3'd2: begin
            ram_waddr = ADDR_W'(limit);
            ram_wdata = '0;
          end
          default: begin
            ram_waddr = ADDR_W'(limit + OFF_W'(1));
            ram_wdata = FLAG_ALLOC;
          end
        endcase
      end
      ST_ACHK: ram_raddr = ADDR_W'(off + OFF_W'(1));
      ST_AWR: begin
        ram_we = 1'b1;
        unique case (step)
          3'd0: begin
            ram_waddr = ADDR_W'(off);
            ram_wdata = WORD_W'(prev_off);
          end
          3'd1: begin
            ram_waddr = ADDR_W'(off + OFF_W'(1));
            ram_wdata = take_whole ? (FLAG_ALLOC | WORD_W'(size_q))
                                   : (FLAG_ALLOC | WORD_W'(req_words));
          end
          3'd2: begin
            ram_waddr = ADDR_W'(split_at);
            ram_wdata = WORD_W'(off);
          end
          3'd3: begin
            ram_waddr = ADDR_W'(split_at + OFF_W'(1));
            ram_wdata = WORD_W'(leftover) - WORD_W'(HDR);
          end
          default: begin
            ram_waddr = ADDR_W'(follow);
            ram_wdata = WORD_W'(split_at);
          end
        endcase
      end
      ST_FCHK: ram_raddr = ADDR_W'(hdl - FIELD_W'(1));
      ST_FW:   ram_raddr = ADDR_W'(off);
      ST_FP: begin
        if (off != '0) begin
          ram_raddr = ADDR_W'(ram_rdata[OFF_W-1:0] + OFF_W'(1));
        end else begin
          ram_raddr = ADDR_W'(follow + OFF_W'(1));
        end
      end
      ST_FPF: ram_raddr = ADDR_W'(nxt + OFF_W'(1));
      ST_FWR: begin
        ram_we = 1'b1;
        if (step == 3'd0) begin
          ram_waddr = ADDR_W'(mod_off + OFF_W'(1));
          ram_wdata = total[WORD_W-1:0];
        end else begin
          ram_waddr = ADDR_W'(new_next[OFF_W-1:0]);
          ram_wdata = WORD_W'(mod_off);
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      pool_words <= CFG_W'(4096);
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_words <= cfg_wdata;
      end
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_words  <= req.request_words;
            hdl        <= req.handle;
            limit      <= active_n - OFF_W'(HDR);
            off        <= '0;
            prev_off   <= '0;
            step       <= '0;
            res_grant  <= '0;
            unique case (req.operation)
              OP_FORMAT: begin
                res_status <= STATUS_OK;
                state      <= ST_FMT;
              end
              OP_ALLOC: begin
                if (req.request_words == '0) begin
                  res_status <= STATUS_BAD_REQ;
                  state      <= ST_DONE;
                end else begin
                  res_status <= STATUS_OK;
                  state      <= ST_ACHK;
                end
              end
              OP_FREE: begin
                res_status <= STATUS_OK;
                state      <= ST_FCHK;
              end
              default: begin
                res_status <= STATUS_BAD_REQ;
                state      <= ST_DONE;
              end
            endcase
          end
        end

        // Format: four header words
        ST_FMT: begin
          step <= step + 3'd1;
          if (step == 3'd3) begin
            state <= ST_DONE;
          end
        end

        // Allocate walk: bound check, then header read
        ST_ACHK: begin
          if (off + OFF_W'(HDR) > limit) begin
            res_status <= STATUS_NOFIT;
            state      <= ST_DONE;
          end else begin
            state <= ST_AEVAL;
          end
        end

        ST_AEVAL: begin
          if (ram_rdata == FLAG_ALLOC || walk_end > WORD_W'(limit)) begin
            res_status <= STATUS_NOFIT;
            state      <= ST_DONE;
          end else if (!ram_rdata[WORD_W-1] && SIZE_W'(req_words) <= rd_size) begin
            size_q <= rd_size;
            step   <= '0;
            state  <= ST_AWR;
          end else begin
            prev_off <= off;
            off      <= OFF_W'(walk_end);
            state    <= ST_ACHK;
          end
        end

        // Header updates of the chosen block
        ST_AWR: begin
          step <= step + 3'd1;
          if ((step == 3'd1 && take_whole) || step == 3'd4) begin
            res_grant <= FIELD_W'(off + OFF_W'(HDR));
            state     <= ST_DONE;
          end
        end

        // Free: handle range
        ST_FCHK: begin
          if (hdl < FIELD_W'(HDR) || OFF_W'(hdl) > limit) begin
            res_status <= STATUS_BAD_HDL;
            state      <= ST_DONE;
          end else begin
            off   <= OFF_W'(hdl - FIELD_W'(HDR));
            state <= ST_FW;
          end
        end

        // Size word of the block being freed
        ST_FW: begin
          if (!ram_rdata[WORD_W-1] || ram_rdata == FLAG_ALLOC) begin
            res_status <= STATUS_BAD_HDL;
            state      <= ST_DONE;
          end else begin
            size_q <= rd_size;
            state  <= ST_FP;
          end
        end

        // Back link and end of block
        ST_FP: begin
          if ((off != '0 && ram_rdata >= WORD_W'(off)) || free_end > WORD_W'(limit)) begin
            res_status <= STATUS_BAD_HDL;
            state      <= ST_DONE;
          end else begin
            prev_off <= ram_rdata[OFF_W-1:0];
            nxt      <= follow;
            mod_off  <= off;
            total    <= (SIZE_W+3)'(size_q);
            state    <= (off != '0) ? ST_FPF : ST_FNF;
          end
        end

        // Merge with a free previous block
        ST_FPF: begin
          if (!ram_rdata[WORD_W-1]) begin
            mod_off <= prev_off;
            total   <= (SIZE_W+3)'(size_q) + (SIZE_W+3)'(HDR) + (SIZE_W+3)'(rd_size);
          end
          state <= ST_FNF;
        end

        // Merge with a free following block
        ST_FNF: begin
          if (ram_rdata[WORD_W-1]) begin
            new_next <= (SIZE_W+2)'(nxt);
          end else begin
            total    <= total + (SIZE_W+3)'(HDR) + (SIZE_W+3)'(rd_size);
            new_next <= (SIZE_W+2)'(nxt) + (SIZE_W+2)'(HDR) + (SIZE_W+2)'(rd_size);
          end
          state <= ST_FCMP;
        end

        ST_FCMP: begin
          if (new_next > (SIZE_W+2)'(limit) ||
              (SIZE_W+3)'(mod_off) + (SIZE_W+3)'(HDR) + total != (SIZE_W+3)'(new_next)) begin
            res_status <= STATUS_BAD_HDL;
            state      <= ST_DONE;
          end else begin
            step  <= '0;
            state <= ST_FWR;
          end
        end

        ST_FWR: begin
          step <= step + 3'd1;
          if (step == 3'd1) begin
            state <= ST_DONE;
          end
        end

        // Hand the result to the output register
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_grant  <= (res_status == STATUS_OK) ? res_grant : '0;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/btpa_ram.sv -----
module btpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/tb_boundary_tag_pool_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_boundary_tag_pool_allocator_core;
  import btpa_pkg::*;

  localparam op_t OP_ILLEGAL      = 2'd3;
  localparam int  FIELD_MAX       = (1 << FIELD_W) - 1;
  localparam int  CFG_MAX         = (1 << CFG_W) - 1;
  localparam int  POOL_CFG_RESET  = 4096;
  localparam int  DRAIN_CYCLES    = 64;

  typedef struct packed {
    status_t status;
    field_t  granted;
  } grant_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  btpa_req_if req_bus ();
  btpa_rsp_if rsp_bus ();

  boundary_tag_pool_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  // Shadow copy of the pool plus a mask of words that have been written
  bit [WORD_W-1:0] shadow_pool  [POOL_WORDS];
  bit              shadow_known [POOL_WORDS];
  int unsigned     shadow_cfg;
  bit              touched_unknown;

  grant_t pending_grants [$];
  field_t live_handles [$];
  int     mismatches;
  int     send_idle_pct;
  int     stall_pct;
  int     hold_left;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pool predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned pool_span();
    longint unsigned n;
    n = shadow_cfg;
    if (n > ACTIVE_MAX) n = ACTIVE_MAX;
    if (n < ACTIVE_MIN) n = ACTIVE_MIN;
    return n;
  endfunction

  // Reads flag any word that was never written; such an item must not be sent
  function automatic logic [WORD_W-1:0] peek(longint unsigned a);
    if (a >= POOL_WORDS) return '0;
    if (!shadow_known[a]) touched_unknown = 1'b1;
    return shadow_pool[a];
  endfunction

  function automatic void poke(longint unsigned a, longint unsigned v, bit commit);
    if (commit && a < POOL_WORDS) begin
      shadow_pool[a]  = v[WORD_W-1:0];
      shadow_known[a] = 1'b1;
    end
  endfunction

  function automatic status_t alloc_first_fit(longint unsigned n, longint unsigned want,
                                              bit commit, output field_t granted);
    longint unsigned   off, prev, lim, size, split, follow;
    logic [WORD_W-1:0] w;
    status_t           st;
    bit                walking;
    off     = 0;
    prev    = 0;
    lim     = n - HDR;
    granted = '0;
    st      = (want == 0) ? STATUS_BAD_REQ : STATUS_NOFIT;
    walking = (want != 0);
    while (walking) begin
      if (off + HDR > lim) begin
        walking = 1'b0;
      end else begin
        w    = peek(off + 1);
        size = w & SIZE_MASK;
        if (w == FLAG_ALLOC || off + HDR + size > lim) begin
          walking = 1'b0;
        end else if (!w[WORD_W-1] && want <= size) begin
          poke(off, prev, commit);
          if (size - want <= HDR) begin
            // leftover too small for a header: hand out the whole block
            poke(off + 1, size | FLAG_ALLOC, commit);
          end else begin
            split  = off + HDR + want;
            follow = off + HDR + size;
            poke(off + 1, want | FLAG_ALLOC, commit);
            poke(split, off, commit);
            poke(split + 1, size - want - HDR, commit);
            poke(follow, split, commit);
          end
          granted = field_t'(off + HDR);
          st      = STATUS_OK;
          walking = 1'b0;
        end else begin
          prev = off;
          off  = off + HDR + size;
        end
      end
    end
    return st;
  endfunction

  function automatic status_t free_and_merge(longint unsigned n, longint unsigned hdl,
                                             bit commit);
    longint unsigned   cur, size, prv, nxt, base, total, after, lim;
    logic [WORD_W-1:0] w, pw, nw;
    lim = n - HDR;
    if (hdl < HDR) return STATUS_BAD_HDL;
    cur = hdl - HDR;
    if (cur + HDR > lim) return STATUS_BAD_HDL;
    prv = peek(cur);
    w   = peek(cur + 1);
    if (!w[WORD_W-1] || w == FLAG_ALLOC) return STATUS_BAD_HDL;
    size = w & SIZE_MASK;
    if (cur != 0 && prv >= cur) return STATUS_BAD_HDL;
    nxt = cur + HDR + size;
    if (nxt > lim) return STATUS_BAD_HDL;
    // merge backward into a free predecessor
    base  = cur;
    total = size;
    if (cur != 0) begin
      pw = peek(prv + 1);
      if (!pw[WORD_W-1]) begin
        base  = prv;
        total = size + HDR + (pw & SIZE_MASK);
      end
    end
    // merge forward into a free successor
    nw    = peek(nxt + 1);
    after = nxt;
    if (!nw[WORD_W-1]) begin
      total = total + HDR + (nw & SIZE_MASK);
      after = nxt + HDR + (nw & SIZE_MASK);
    end
    if (after > lim || base + HDR + total != after) return STATUS_BAD_HDL;
    poke(base + 1, total, commit);
    poke(after, base, commit);
    return STATUS_OK;
  endfunction

  function automatic grant_t pool_apply(op_t op, field_t want, field_t hdl, bit commit);
    grant_t          r;
    longint unsigned n;
    field_t          g;
    n               = pool_span();
    g               = '0;
    touched_unknown = 1'b0;
    case (op)
      OP_FORMAT: begin
        poke(0, 0, commit);
        poke(1, n - 2 * HDR, commit);
        poke(n - HDR, 0, commit);
        poke(n - HDR + 1, FLAG_ALLOC, commit);
        r.status = STATUS_OK;
      end
      OP_ALLOC: r.status = alloc_first_fit(n, want, commit, g);
      OP_FREE:  r.status = free_and_merge(n, hdl, commit);
      default:  r.status = STATUS_BAD_REQ;
    endcase
    r.granted = (r.status == STATUS_OK) ? g : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, response stall and result checker
  // ---------------------------------------------------------------------------

  task automatic push_op(op_t op, field_t want, field_t hdl);
    grant_t due;
    int     idx;
    due = pool_apply(op, want, hdl, 1'b0);
    if (touched_unknown) op = OP_ILLEGAL;
    due = pool_apply(op, want, hdl, 1'b1);
    if (op == OP_FORMAT) live_handles.delete();
    if (due.status == STATUS_OK && op == OP_ALLOC) live_handles.push_back(due.granted);
    if (due.status == STATUS_OK && op == OP_FREE) begin
      idx = 0;
      while (idx < live_handles.size()) begin
        if (live_handles[idx] == hdl) live_handles.delete(idx);
        else idx++;
      end
    end
    pending_grants.push_back(due);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.operation     <= op;
    req_bus.request_words <= want;
    req_bus.handle        <= hdl;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic settle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_pool_words(int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we     <= 1'b0;
    shadow_cfg  = v & CFG_MAX;
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    grant_t oldest;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d granted_handle %0d",
               rsp_bus.status, rsp_bus.granted_handle);
        mismatches++;
      end else begin
        oldest = pending_grants.pop_front();
        if (rsp_bus.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, rsp_bus.status);
          mismatches++;
        end
        if (rsp_bus.granted_handle !== oldest.granted) begin
          $error("granted_handle: expected %0d, got %0d", oldest.granted,
                 rsp_bus.granted_handle);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic field_t pick_request(longint unsigned n);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4)  return '0;
    if (r < 12) return field_t'($urandom_range(FIELD_MAX));
    if (r < 22) return field_t'($urandom_range(int'(n - 2 * HDR), 1));
    return field_t'($urandom_range(int'(n >> 4) + 1, 1));
  endfunction

  // Mostly alloc/free of live blocks, plus stray frees, formats and illegal ops
  task automatic random_op();
    int unsigned     r, tries;
    longint unsigned n;
    field_t          hdl;
    n = pool_span();
    r = $urandom_range(99);
    if (r < 3) begin
      push_op(OP_FORMAT, field_t'($urandom), field_t'($urandom));
    end else if (r < 6) begin
      push_op(OP_ILLEGAL, field_t'($urandom), field_t'($urandom));
    end else if (r < 50 || (r < 82 && live_handles.size() == 0)) begin
      push_op(OP_ALLOC, pick_request(n), field_t'($urandom));
    end else if (r < 82) begin
      hdl = live_handles[$urandom_range(live_handles.size() - 1)];
      push_op(OP_FREE, field_t'($urandom), hdl);
    end else begin
      // stray handle; retry, up to eight times, until its header words are defined
      tries           = 0;
      touched_unknown = 1'b1;
      while (touched_unknown && tries < 8) begin
        if (r < 92) hdl = field_t'($urandom_range(int'(n) + 1));
        else        hdl = field_t'($urandom_range(FIELD_MAX));
        void'(pool_apply(OP_FREE, '0, hdl, 1'b0));
        tries++;
      end
      push_op(OP_FREE, field_t'($urandom), hdl);
    end
  endtask

  // Full-size pool: bad requests, no-fit, whole-pool grant, handle range checks
  task automatic test_full_pool_edges();
    push_op(OP_FORMAT, '0, '0);
    push_op(OP_ALLOC, '0, '0);
    push_op(OP_ILLEGAL, field_t'(FIELD_MAX), field_t'(FIELD_MAX));
    push_op(OP_ALLOC, 4093, '0);
    push_op(OP_ALLOC, 4092, '0);
    push_op(OP_FREE, '0, 1);
    push_op(OP_FREE, '0, 2);
    push_op(OP_FREE, '0, 2);
    push_op(OP_FREE, '0, field_t'(FIELD_MAX));
    settle();
  endtask

  // Splits, merges on both sides, and a stale header whose back link is not below it
  task automatic test_split_and_merge();
    set_pool_words(64);
    push_op(OP_FORMAT, '0, '0);
    push_op(OP_ALLOC, 9, '0);
    push_op(OP_ALLOC, 49, '0);
    push_op(OP_FORMAT, '0, '0);
    push_op(OP_ALLOC, 8, '0);
    push_op(OP_ALLOC, 8, '0);
    push_op(OP_ALLOC, 8, '0);
    push_op(OP_FREE, '0, 13);
    push_op(OP_FREE, '0, 2);
    push_op(OP_FREE, '0, 22);
    push_op(OP_FREE, '0, 12);
    push_op(OP_ALLOC, 58, '0);
    settle();
  endtask

  // Pool size changed without a format, then the smallest pool
  task automatic test_stale_and_tiny_pool();
    set_pool_words(128);
    push_op(OP_FREE, '0, 64);
    push_op(OP_ALLOC, 10, '0);
    settle();
    set_pool_words(0);
    push_op(OP_FORMAT, '0, '0);
    push_op(OP_ALLOC, 4, '0);
    push_op(OP_ALLOC, 1, '0);
    push_op(OP_FREE, '0, 2);
    settle();
  endtask

  task automatic test_back_to_back();
    set_pool_words(CFG_MAX);
    send_idle_pct = 0;
    stall_pct     = 0;
    push_op(OP_FORMAT, '0, '0);
    repeat (160) random_op();
    settle();
  endtask

  task automatic test_sender_gaps();
    set_pool_words(256);
    send_idle_pct = 67;
    stall_pct     = 0;
    push_op(OP_FORMAT, '0, '0);
    repeat (160) random_op();
    settle();
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_receiver_backpressure();
    set_pool_words(ACTIVE_MAX);
    send_idle_pct = 0;
    stall_pct     = 67;
    hold_left     = 400;
    push_op(OP_FORMAT, '0, '0);
    repeat (160) random_op();
    settle();
  endtask

  task automatic test_both_sides_idle();
    set_pool_words(100);
    send_idle_pct = 10;
    stall_pct     = 10;
    push_op(OP_FORMAT, '0, '0);
    repeat (160) random_op();
    settle();
  endtask

  // Pool size changes between short bursts, with no forced format
  task automatic test_reconfig_churn();
    int unsigned sel, words;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (8) begin
      sel = $urandom_range(6);
      case (sel)
        0:       words = 0;
        1:       words = 7;
        2:       words = ACTIVE_MIN;
        3:       words = 9;
        4:       words = $urandom_range(512, ACTIVE_MIN);
        5:       words = ACTIVE_MAX;
        default: words = CFG_MAX;
      endcase
      set_pool_words(words);
      repeat (25) random_op();
      settle();
    end
  endtask

  // Idling mix redrawn every twenty requests
  task automatic test_mixed_idle();
    set_pool_words(512);
    push_op(OP_FORMAT, '0, '0);
    repeat (8) begin
      send_idle_pct = $urandom_range(1) ? 67 : 0;
      stall_pct     = $urandom_range(1) ? 67 : 0;
      repeat (20) random_op();
    end
    settle();
  endtask

  initial begin
    req_bus.valid         = 1'b0;
    req_bus.operation     = OP_FORMAT;
    req_bus.request_words = '0;
    req_bus.handle        = '0;
    rsp_bus.ready         = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    hold_left             = 0;
    mismatches            = 0;
    shadow_cfg            = POOL_CFG_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_pool_edges();
    test_split_and_merge();
    test_stale_and_tiny_pool();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_both_sides_idle();
    test_reconfig_churn();
    test_mixed_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #300_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
design/btpa_pkg.sv
design/btpa_req_if.sv
design/btpa_rsp_if.sv
design/btpa_ram.sv
design/boundary_tag_pool_allocator_core.sv
tb/sv/tb_boundary_tag_pool_allocator_core.sv
